### design/asrt_pkg.sv
package asrt_pkg;

	localparam int IN_DATA_W  = 136;
	localparam int OUT_DATA_W = 128;
	localparam int OPCODE_W   = 2;
	localparam int HALF_W     = 64;
	localparam int NUM_BYTES  = 16;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [7:0] GF_POLY = 8'h1b;

	typedef enum logic [OPCODE_W-1:0] {
		OP_SUB_BYTES       = 2'd0,
		OP_SHIFT_ROWS      = 2'd1,
		OP_MIX_COLUMNS     = 2'd2,
		OP_INV_MIX_COLUMNS = 2'd3
	} op_t;

	// byte k of the state sits at index k, byte 0 in the top bits
	typedef logic [0:NUM_BYTES-1][7:0] state_t;

	typedef struct packed {
		op_t    op;
		state_t st;
	} item_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	// multiply by x modulo the field polynomial
	function automatic logic [7:0] gf_x2(input logic [7:0] v);
		gf_x2 = {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
	endfunction

	function automatic state_t sub_bytes(input state_t s);
		state_t o;
		for (int k = 0; k < NUM_BYTES; k++) begin
			o[k] = SBOX[s[k]];
		end
		return o;
	endfunction

	// row r rotated left by r
	function automatic state_t shift_rows(input state_t s);
		state_t o;
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				o[4*r + c] = s[4*r + ((c + r) % 4)];
			end
		end
		return o;
	endfunction

	// forward matrix 02 03 01 01, inverse matrix 0e 0b 0d 09
	function automatic state_t mix_columns(input state_t s, input logic inv);
		state_t     o;
		logic [7:0] a [4];
		logic [7:0] a2 [4];
		logic [7:0] a4 [4];
		logic [7:0] a8 [4];
		logic [7:0] m9, mb, md, me;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				a[r]  = s[4*r + c];
				a2[r] = gf_x2(a[r]);
				a4[r] = gf_x2(a2[r]);
				a8[r] = gf_x2(a4[r]);
			end
			for (int r = 0; r < 4; r++) begin
				me = a8[r] ^ a4[r] ^ a2[r];
				mb = a8[(r+1)%4] ^ a2[(r+1)%4] ^ a[(r+1)%4];
				md = a8[(r+2)%4] ^ a4[(r+2)%4] ^ a[(r+2)%4];
				m9 = a8[(r+3)%4] ^ a[(r+3)%4];
				if (inv) begin
					o[4*r + c] = me ^ mb ^ md ^ m9;
				end else begin
					o[4*r + c] = a2[r] ^ a2[(r+1)%4] ^ a[(r+1)%4] ^ a[(r+2)%4]
						^ a[(r+3)%4];
				end
			end
		end
		return o;
	endfunction

endpackage

### design/asrt_front.sv
module asrt_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [asrt_pkg::IN_DATA_W-1:0] in_data,
	output logic                    push_valid,
	input  logic                    push_ready,
	output asrt_pkg::item_t         push_item
);
	import asrt_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	item_t item_in;

	// classify the opcode and unpack the two state halves
	always_comb begin
		item_in.op = op_t'(in_data[OPCODE_W-1:0]);
		item_in.st = {in_data[OPCODE_W +: HALF_W], in_data[OPCODE_W + HALF_W +: HALF_W]};
	end

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item_in;
		end
	end

endmodule

### design/asrt_queue.sv
module asrt_queue #(
	parameter int QueueDepth = asrt_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  asrt_pkg::item_t push_item,
	output logic            head_valid,
	input  logic            pop,
	output asrt_pkg::item_t head_item
);
	import asrt_pkg::*;

	localparam int PtrW = $clog2(QueueDepth);
	localparam int CntW = $clog2(QueueDepth + 1);

	item_t           mem_q [QueueDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (count_q != CntW'(QueueDepth));
	assign head_valid = (count_q != '0);
	assign head_item  = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

### design/asrt_back.sv
module asrt_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  asrt_pkg::item_t head_item,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [asrt_pkg::OUT_DATA_W-1:0] out_data
);
	import asrt_pkg::*;

	logic   out_valid_q;
	state_t res_q;
	state_t res_d;

	always_comb begin
		case (head_item.op)
			OP_SUB_BYTES:       res_d = sub_bytes(head_item.st);
			OP_SHIFT_ROWS:      res_d = shift_rows(head_item.st);
			OP_MIX_COLUMNS:     res_d = mix_columns(head_item.st, 1'b0);
			OP_INV_MIX_COLUMNS: res_d = mix_columns(head_item.st, 1'b1);
			default:            res_d = head_item.st;
		endcase
	end

	assign pop       = head_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	// result_high in the low half, result_low above it
	assign out_data  = {res_q[8:15], res_q[0:7]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_d;
		end
	end

endmodule

### design/aes_state_round_transform_top.sv
// latency: an accepted request passes the front register, the queue and the output register in turn
// throughput: one request per cycle when not stalled, set by the combinational back end
// a queue of QueueDepth entries lets the front keep accepting while the output is stalled
// reset: arst_n clears all valid flags and queue pointers at once; payload registers hold
// no state needed after reset, and the s-box is a fixed constant table
module aes_state_round_transform_top #(
	parameter int QueueDepth = asrt_pkg::QUEUE_DEPTH_DEF  // 2 to 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// request channel
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// opcode [1:0], state_high [65:2], state_low [129:66], zero pad [135:130]
	input  logic [asrt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// result channel
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// result_high [63:0], result_low [127:64]
	output logic [asrt_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import asrt_pkg::*;

	// front stage to queue
	logic  push_valid;
	logic  push_ready;
	item_t push_item;

	// queue head to back end
	logic  head_valid;
	logic  pop;
	item_t head_item;

	// front: registers the request and decodes the opcode
	asrt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_data    (s_axis_tdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	// decoupling queue so the two sides stall independently
	asrt_queue #(
		.QueueDepth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.head_valid (head_valid),
		.pop        (pop),
		.head_item  (head_item)
	);

	// back end: byte-parallel transform into the output register
	asrt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_data   (m_axis_tdata)
	);

endmodule

### design/asrt_checker.sv
module asrt_checker #(
	parameter int QueueDepth = asrt_pkg::QUEUE_DEPTH_DEF
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [asrt_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import asrt_pkg::*;

	// front register, queue and output register
	localparam int MaxOut = QueueDepth + 2;
	localparam int CntW   = $clog2(MaxOut + 2) + 1;

	logic [CntW-1:0] outstanding_q;
	logic            in_acc;
	logic            out_acc;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else if (in_acc && !out_acc) begin
			outstanding_q <= outstanding_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			outstanding_q <= outstanding_q - 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> outstanding_q != '0)
		else $error("result shown with no request in flight");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q <= CntW'(MaxOut))
		else $error("more requests in flight than storage allows");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q == '0 && !$past(in_acc) |-> s_axis_tready)
		else $error("request side blocked while block is empty");

endmodule

bind aes_state_round_transform_top asrt_checker #(.QueueDepth(QueueDepth)) u_asrt_checker (.*);

### dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	import asrt_pkg::*;

	localparam int CLK_PERIOD    = 20;
	localparam int ITEMS_PER_PH  = 350;
	localparam int NUM_PHASES    = 4;
	localparam int DRAIN_CYCLES  = 8;
	// whole run: ~1420 requests, in later phases held back by sender gaps and/or receiver stalls
	localparam int CYCLE_LIMIT   = 200000;

	// one request as the stimulus sees it
	typedef struct {
		op_t         op;
		logic [63:0] hi;
		logic [63:0] lo;
	} round_req_t;

	// idle settings per phase: percent of cycles the sender holds back / receiver stalls
	localparam int SEND_IDLE [NUM_PHASES] = '{0, 80, 0, 30};
	localparam int RECV_IDLE [NUM_PHASES] = '{0, 0, 80, 30};

	// directed states, bytes 0..15 from the top bits down
	localparam logic [127:0] DIRECTED_STATES [5] = '{
		128'h0000_0000_0000_0000_0000_0000_0000_0000,  // all zero
		128'hffff_ffff_ffff_ffff_ffff_ffff_ffff_ffff,  // all ones
		128'h0001_0203_0405_0607_0809_0a0b_0c0d_0e0f,  // distinct bytes, shows row moves
		128'h8080_8080_8080_8080_8080_8080_8080_8080,  // top bit set everywhere, forces reduction
		128'h55aa_55aa_aa55_aa55_55aa_55aa_aa55_aa55   // alternating bit patterns
	};

	logic                  clk    = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	round_req_t       pending_reqs[$];
	logic [127:0]     expected_states[$];
	logic [7:0]       sub_table [256];
	logic [127:0]     oldest_state;
	int               send_idle_pct = 0;
	int               recv_idle_pct = 0;
	int               errors = 0;
	int               cycles = 0;

	aes_state_round_transform_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		// opcode [1:0], state_high [65:2], state_low [129:66], zero pad [135:130]
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		// result_high [63:0], result_low [127:64]
		.m_axis_tdata  (m_axis_tdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// product in GF(2^8) with the AES polynomial
	function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		acc = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				acc = acc ^ a;
			end
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
		end
		return acc;
	endfunction

	function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
		logic [7:0] r;
		r = (x << n) | (x >> (8 - n));
		return r;
	endfunction

	// s-box built from first principles: field inverse then the affine map
	function automatic logic [7:0] sbox_entry(input logic [7:0] b);
		logic [7:0] inv;
		inv = 8'h00;
		for (int x = 1; x < 256; x++) begin
			if (gf_times(b, 8'(x)) == 8'h01) begin
				inv = 8'(x);
			end
		end
		return inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3) ^ rotl8(inv, 4) ^ 8'h63;
	endfunction

	// expected {result_low, result_high} for one packed request
	function automatic logic [127:0] predict_round(input logic [IN_DATA_W-1:0] d);
		logic [7:0]  s [16];
		logic [7:0]  t [16];
		logic [7:0]  coef [4];
		logic [7:0]  col [4];
		logic [7:0]  acc;
		logic [63:0] hi;
		logic [63:0] lo;
		op_t         op;
		op = op_t'(d[1:0]);
		hi = d[65:2];
		lo = d[129:66];
		for (int k = 0; k < 8; k++) begin
			s[k]     = hi[63 - 8*k -: 8];
			s[k + 8] = lo[63 - 8*k -: 8];
		end
		case (op)
			OP_SUB_BYTES: begin
				for (int k = 0; k < 16; k++) begin
					t[k] = sub_table[s[k]];
				end
			end
			OP_SHIFT_ROWS: begin
				for (int r = 0; r < 4; r++) begin
					for (int c = 0; c < 4; c++) begin
						t[4*r + c] = s[4*r + ((c + r) & 3)];
					end
				end
			end
			default: begin
				if (op == OP_MIX_COLUMNS) begin
					coef = '{8'h02, 8'h03, 8'h01, 8'h01};
				end else begin
					coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
				end
				// circulant matrix applied to each column
				for (int c = 0; c < 4; c++) begin
					for (int r = 0; r < 4; r++) begin
						col[r] = s[4*r + c];
					end
					for (int r = 0; r < 4; r++) begin
						acc = 8'h00;
						for (int j = 0; j < 4; j++) begin
							acc = acc ^ gf_times(coef[(j - r + 4) & 3], col[j]);
						end
						t[4*r + c] = acc;
					end
				end
			end
		endcase
		for (int k = 0; k < 8; k++) begin
			hi[63 - 8*k -: 8] = t[k];
			lo[63 - 8*k -: 8] = t[k + 8];
		end
		return {lo, hi};
	endfunction

	// random half-state: half dense random, the rest all-zero, all-one, single-bit and single-zero-bit words
	function automatic logic [63:0] rand_half();
		logic [63:0] v;
		case ($urandom_range(7))
			0: v = 64'h0;
			1: v = '1;
			2: v = 64'h1 << $urandom_range(63);
			3: v = ~(64'h1 << $urandom_range(63));
			default: v = {$urandom, $urandom};
		endcase
		return v;
	endfunction

	// request driver: a new request only once the previous one has gone
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				s_axis_tdata  <= {6'b0, pending_reqs[0].lo, pending_reqs[0].hi,
					pending_reqs[0].op};
				s_axis_tvalid <= 1'b1;
				void'(pending_reqs.pop_front());
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// result side back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// monitor: check results first, then record the request accepted at this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_states.size() == 0) begin
					$error("result with nothing pending: %h", m_axis_tdata);
					errors++;
				end else begin
					oldest_state = expected_states.pop_front();
					if (m_axis_tdata[63:0] !== oldest_state[63:0]) begin
						$error("result_high: expected %h, actual %h",
							oldest_state[63:0], m_axis_tdata[63:0]);
						errors++;
					end
					if (m_axis_tdata[127:64] !== oldest_state[127:64]) begin
						$error("result_low: expected %h, actual %h",
							oldest_state[127:64], m_axis_tdata[127:64]);
						errors++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				expected_states.insert(expected_states.size(), predict_round(s_axis_tdata));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("aes_state_round_transform_top: mismatch");
			$finish;
		end
	end

	initial begin
		round_req_t req;
		op_t        op;
		for (int b = 0; b < 256; b++) begin
			sub_table[b] = sbox_entry(8'(b));
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			send_idle_pct = SEND_IDLE[ph];
			recv_idle_pct = RECV_IDLE[ph];
			if (ph == 0) begin
				// every transform on each edge-case state
				op = OP_SUB_BYTES;
				for (int o = 0; o < 4; o++) begin
					for (int d = 0; d < 5; d++) begin
						req.op = op;
						req.hi = DIRECTED_STATES[d][127:64];
						req.lo = DIRECTED_STATES[d][63:0];
						pending_reqs.insert(pending_reqs.size(), req);
					end
					op = op.next();
				end
			end
			for (int i = 0; i < ITEMS_PER_PH; i++) begin
				req.op = op_t'($urandom_range(3));
				req.hi = rand_half();
				req.lo = rand_half();
				pending_reqs.insert(pending_reqs.size(), req);
			end
			// let the phase drain before changing idle settings
			while (pending_reqs.size() > 0 || s_axis_tvalid || expected_states.size() > 0) begin
				@(posedge clk);
			end
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && expected_states.size() == 0) begin
			$display("aes_state_round_transform_top: match");
		end else begin
			$display("aes_state_round_transform_top: mismatch");
		end
		$finish;
	end

endmodule
